[src/sjf_pkg.sv]
// Shared types and codes for the shortest-job-first ready pool.
// No dependencies; the interfaces, the pool and its testbench refer to this package.
package sjf_pkg;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [1:0] STATUS_DISPATCHED = 2'd0;
    localparam logic [1:0] STATUS_ADDED      = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;
    localparam logic [1:0] STATUS_EMPTY      = 2'd3;

    localparam int ID_W      = 16;
    localparam int ARRIVAL_W = 32;
    localparam int BURST_W   = 16;
    localparam int STAMP_W   = 32;
    localparam int WAITING_W = 5;

    typedef logic [ID_W-1:0]      id_t;
    typedef logic [ARRIVAL_W-1:0] arrival_t;
    typedef logic [BURST_W-1:0]   burst_t;
    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [WAITING_W-1:0] waiting_t;

    typedef struct packed {
        id_t      id;
        arrival_t arrival;
        burst_t   burst;
        stamp_t   stamp;
    } job_t;

endpackage

[src/sjf_if.sv]
// Item channels of the shortest-job-first ready pool: job requests in, results out.
// Depends on sjf_pkg for the field types.
interface sjf_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    sjf_pkg::id_t      job_id;
    sjf_pkg::arrival_t arrival;
    sjf_pkg::burst_t   burst;

    modport source (output valid, output op, output job_id, output arrival, output burst,
                    input ready);
    modport sink (input valid, input op, input job_id, input arrival, input burst,
                  output ready);
endinterface

interface sjf_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    sjf_pkg::id_t      out_id;
    sjf_pkg::arrival_t out_arrival;
    sjf_pkg::burst_t   out_burst;
    sjf_pkg::waiting_t waiting;

    modport source (output valid, output status, output out_id, output out_arrival,
                    output out_burst, output waiting, input ready);
    modport sink (input valid, input status, input out_id, input out_arrival,
                  input out_burst, input waiting, output ready);
endinterface

[src/sjf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sjf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/shortest_job_first_pool.sv]
// Shortest-job-first ready pool: add a job or dispatch the waiting job with the smallest burst.
// An add walks the valid bits for the lowest free slot (ST_FREE) and writes the job there;
// a dispatch reads every slot from the RAM in turn (ST_SCAN, ST_DRAIN) to find the minimum burst.
// A full add or an empty dispatch goes straight to the result. One item is worked on at a time.
// Reset clears all valid bits and the job count at once; no clearing pass is needed.
// Depends on sjf_pkg, sjf_if (sjf_in_if, sjf_out_if) and sjf_ram.
module shortest_job_first_pool #(
    parameter int SLOTS = 16
) (
    input logic      clk,
    input logic      rst_n,
    sjf_in_if.sink   items,
    sjf_out_if.source results
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int JW = $bits(sjf_pkg::job_t);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FREE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [CW-1:0]       count_reg, count_next;
    sjf_pkg::stamp_t     stamp_reg, stamp_next;
    logic                p_go_reg, p_go_next;
    logic                p_live_reg, p_live_next;
    logic [IW-1:0]       p_idx_reg;
    logic                best_have_reg, best_have_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    sjf_pkg::id_t        best_id_reg, best_id_next;
    sjf_pkg::arrival_t   best_arr_reg, best_arr_next;
    sjf_pkg::burst_t     best_burst_reg, best_burst_next;
    sjf_pkg::stamp_t     best_age_reg, best_age_next;
    logic [1:0]          res_status_reg, res_status_next;
    sjf_pkg::id_t        in_id_reg;
    sjf_pkg::arrival_t   in_arr_reg;
    sjf_pkg::burst_t     in_burst_reg;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg, out_status_next;
    sjf_pkg::id_t        out_id_reg, out_id_next;
    sjf_pkg::arrival_t   out_arr_reg, out_arr_next;
    sjf_pkg::burst_t     out_burst_reg, out_burst_next;
    sjf_pkg::waiting_t   out_waiting_reg, out_waiting_next;

    logic                in_take;
    logic                wr_en;
    logic                rd_en;
    sjf_pkg::job_t       wr_job;
    logic [JW-1:0]       rd_data;
    sjf_pkg::job_t       rd_job;
    sjf_pkg::stamp_t     rd_age;
    logic                better;
    logic                is_last;
    logic                fin_go;
    logic [CW-1:0]       count_after;
    logic [CW+4:0]       count_wide;

    assign in_take = items.valid && items.ready;
    assign items.ready = (state_reg == ST_IDLE);

    assign results.valid       = out_valid_reg;
    assign results.status      = out_status_reg;
    assign results.out_id      = out_id_reg;
    assign results.out_arrival = out_arr_reg;
    assign results.out_burst   = out_burst_reg;
    assign results.waiting     = out_waiting_reg;

    assign rd_job  = sjf_pkg::job_t'(rd_data);
    assign rd_age  = stamp_reg - rd_job.stamp;
    assign better  = !best_have_reg || (rd_job.burst < best_burst_reg) ||
                     ((rd_job.burst == best_burst_reg) && (rd_age < best_age_reg));
    assign is_last = (idx_reg == IW'(SLOTS - 1));
    assign fin_go  = (state_reg == ST_FIN) && (!out_valid_reg || results.ready);

    assign wr_en  = (state_reg == ST_FREE) && !valid_reg[idx_reg];
    assign wr_job = '{id: in_id_reg, arrival: in_arr_reg, burst: in_burst_reg,
                      stamp: stamp_reg + sjf_pkg::stamp_t'(1)};
    assign rd_en  = (state_reg == ST_SCAN);

    assign count_after = (res_status_reg == sjf_pkg::STATUS_DISPATCHED) ?
                         count_reg - CW'(1) : count_reg;
    assign count_wide  = {5'b0, count_after};

    sjf_ram #(
        .WIDTH (JW),
        .DEPTH (SLOTS)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (JW'(wr_job)),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        stamp_next       = stamp_reg;
        p_go_next        = 1'b0;
        p_live_next      = 1'b0;
        best_have_next   = best_have_reg;
        best_idx_next    = best_idx_reg;
        best_id_next     = best_id_reg;
        best_arr_next    = best_arr_reg;
        best_burst_next  = best_burst_reg;
        best_age_next    = best_age_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_arr_next     = out_arr_reg;
        out_burst_next   = out_burst_reg;
        out_waiting_next = out_waiting_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (p_go_reg && p_live_reg && better)
        begin
            best_have_next  = 1'b1;
            best_idx_next   = p_idx_reg;
            best_id_next    = rd_job.id;
            best_arr_next   = rd_job.arrival;
            best_burst_next = rd_job.burst;
            best_age_next   = rd_age;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    idx_next       = '0;
                    best_have_next = 1'b0;
                    if (items.op == sjf_pkg::OP_ADD)
                    begin
                        if (count_reg == CW'(SLOTS))
                        begin
                            res_status_next = sjf_pkg::STATUS_FULL;
                            state_next      = ST_FIN;
                        end
                        else
                        begin
                            res_status_next = sjf_pkg::STATUS_ADDED;
                            state_next      = ST_FREE;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = sjf_pkg::STATUS_EMPTY;
                            state_next      = ST_FIN;
                        end
                        else
                        begin
                            res_status_next = sjf_pkg::STATUS_DISPATCHED;
                            state_next      = ST_SCAN;
                        end
                    end
                end
            end
            ST_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + CW'(1);
                    stamp_next          = stamp_reg + sjf_pkg::stamp_t'(1);
                    state_next          = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_SCAN:
            begin
                p_go_next   = 1'b1;
                p_live_next = valid_reg[idx_reg];
                if (is_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_waiting_next = count_wide[4:0];
                    count_next       = count_after;
                    state_next       = ST_IDLE;
                    if (res_status_reg == sjf_pkg::STATUS_DISPATCHED)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        out_id_next              = best_id_reg;
                        out_arr_next             = best_arr_reg;
                        out_burst_next           = best_burst_reg;
                    end
                    else
                    begin
                        out_id_next    = '0;
                        out_arr_next   = '0;
                        out_burst_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            stamp_reg     <= '0;
            p_go_reg      <= 1'b0;
            best_have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            stamp_reg     <= stamp_next;
            p_go_reg      <= p_go_next;
            best_have_reg <= best_have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        p_live_reg      <= p_live_next;
        p_idx_reg       <= idx_reg;
        best_idx_reg    <= best_idx_next;
        best_id_reg     <= best_id_next;
        best_arr_reg    <= best_arr_next;
        best_burst_reg  <= best_burst_next;
        best_age_reg    <= best_age_next;
        res_status_reg  <= res_status_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_arr_reg     <= out_arr_next;
        out_burst_reg   <= out_burst_next;
        out_waiting_reg <= out_waiting_next;
        if (in_take)
        begin
            in_id_reg    <= items.job_id;
            in_arr_reg   <= items.arrival;
            in_burst_reg <= items.burst;
        end
    end

endmodule

[verif/tb_shortest_job_first_pool.sv]
// Testbench for the shortest-job-first ready pool: directed and random add and dispatch items.
// A scoreboard class tracks the pool contents and checks every result in order.
// Depends on sjf_pkg, sjf_in_if, sjf_out_if and shortest_job_first_pool.
`timescale 1ns / 1ps

module tb_shortest_job_first_pool;

    import sjf_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 1720;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [1:0] status;
        id_t        id;
        arrival_t   arrival;
        burst_t     burst;
        waiting_t   waiting;
    } pool_outcome_t;

    class pool_scoreboard;
        bit            slot_used[SLOTS];
        id_t           slot_id[SLOTS];
        arrival_t      slot_arrival[SLOTS];
        burst_t        slot_burst[SLOTS];
        int            slot_age[SLOTS];
        int            jobs_waiting;
        int            errors;
        pool_outcome_t outcomes_due[$];

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
            jobs_waiting = 0;
            errors       = 0;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function void note_item(logic op, id_t id, arrival_t arrival, burst_t burst);
            pool_outcome_t o;
            int            pick;
            o.status  = STATUS_EMPTY;
            o.id      = '0;
            o.arrival = '0;
            o.burst   = '0;
            pick      = -1;
            if (op == OP_ADD)
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!slot_used[i])
                        pick = i;
                end
                if (pick < 0)
                    o.status = STATUS_FULL;
                else
                begin
                    foreach (slot_used[i])
                    begin
                        if (slot_used[i])
                            slot_age[i]++;
                    end
                    slot_used[pick]    = 1'b1;
                    slot_id[pick]      = id;
                    slot_arrival[pick] = arrival;
                    slot_burst[pick]   = burst;
                    slot_age[pick]     = 0;
                    jobs_waiting++;
                    o.status = STATUS_ADDED;
                end
            end
            else
            begin
                foreach (slot_used[i])
                begin
                    if (slot_used[i] && (pick < 0 || slot_burst[i] < slot_burst[pick] ||
                        (slot_burst[i] == slot_burst[pick] && slot_age[i] < slot_age[pick])))
                        pick = i;
                end
                if (pick >= 0)
                begin
                    slot_used[pick] = 1'b0;
                    jobs_waiting--;
                    o.status  = STATUS_DISPATCHED;
                    o.id      = slot_id[pick];
                    o.arrival = slot_arrival[pick];
                    o.burst   = slot_burst[pick];
                end
            end
            o.waiting = waiting_t'(jobs_waiting);
            outcomes_due.push_back(o);
        endfunction

        function void check_result(pool_outcome_t got);
            pool_outcome_t want;
            if (outcomes_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result: status %0d id %h arrival %h burst %h waiting %0d",
                             $realtime, got.status, got.id, got.arrival, got.burst, got.waiting);
                return;
            end
            want = outcomes_due.pop_front();
            if (got.status !== want.status || got.id !== want.id || got.arrival !== want.arrival ||
                got.burst !== want.burst || got.waiting !== want.waiting)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("[%0t] mismatch: expected status %0d id %h arrival %h burst %h waiting %0d",
                             $realtime, want.status, want.id, want.arrival, want.burst, want.waiting);
                    $display("[%0t]           actual   status %0d id %h arrival %h burst %h waiting %0d",
                             $realtime, got.status, got.id, got.arrival, got.burst, got.waiting);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   cycles;

    pool_scoreboard book = new();

    sjf_in_if  items_ch();
    sjf_out_if results_ch();

    shortest_job_first_pool #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(items_ch),
        .results(results_ch)
    );

    always #4 clk = ~clk;

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic burst_t pick_burst();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return burst_t'($urandom_range(0, 7));
        else if (r == 5)
            return (r[0] ^ $urandom_range(0, 1)) ? '0 : '1;
        else
            return burst_t'($urandom);
    endfunction

    task automatic offer_job(input logic op, input id_t id, input arrival_t arrival,
                             input burst_t burst);
        int gap;
        gap = calm ? 0 : idle_span();
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid   <= 1'b1;
        items_ch.op      <= op;
        items_ch.job_id  <= id;
        items_ch.arrival <= arrival;
        items_ch.burst   <= burst;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
        book.note_item(op, id, arrival, burst);
    endtask

    task automatic settle();
        items_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (book.pending() != 0);
    endtask

    initial
    begin : cycle_guard
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int            stall;
        pool_outcome_t got;
        stall = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
            begin
                got.status  = results_ch.status;
                got.id      = results_ch.out_id;
                got.arrival = results_ch.out_arrival;
                got.burst   = results_ch.out_burst;
                got.waiting = results_ch.waiting;
                book.check_result(got);
            end
            if (stall > 0)
            begin
                results_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                results_ch.ready <= 1'b1;
                if (!calm)
                    stall = idle_span();
            end
        end
    end

    initial
    begin : job_source
        int   tilt;
        int   add_odds;
        logic op;
        calm = 1'b0;
        tilt = 2;
        rst_n            <= 1'b0;
        items_ch.valid   <= 1'b0;
        items_ch.op      <= OP_ADD;
        items_ch.job_id  <= '0;
        items_ch.arrival <= '0;
        items_ch.burst   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty pool, field extremes, equal bursts, full pool.
        offer_job(OP_DISPATCH, '1, '1, '1);
        offer_job(OP_ADD, '1, '1, '1);
        offer_job(OP_ADD, '0, '0, '0);
        offer_job(OP_ADD, id_t'(1), arrival_t'(100), burst_t'(5));
        offer_job(OP_ADD, id_t'(2), arrival_t'(200), burst_t'(5));
        repeat (5) offer_job(OP_DISPATCH, '0, '0, '0);
        for (int i = 0; i < SLOTS; i++)
            offer_job(OP_ADD, id_t'(16'h0100 + i), arrival_t'($urandom), burst_t'(3));
        offer_job(OP_ADD, id_t'(16'hBEEF), '1, '0);
        settle();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                tilt = $urandom_range(0, 2);
                calm = ($urandom_range(0, 5) == 0);
            end
            if (n == RANDOM_ITEMS / 2)
                settle();
            add_odds = (tilt == 0) ? 80 : (tilt == 1) ? 20 : 50;
            op = ($urandom_range(0, 99) < add_odds) ? OP_ADD : OP_DISPATCH;
            offer_job(op, id_t'($urandom), arrival_t'($urandom), pick_burst());
        end

        settle();
        repeat (2 * SLOTS + 8) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
src/sjf_pkg.sv
src/sjf_if.sv
src/sjf_ram.sv
src/shortest_job_first_pool.sv
verif/tb_shortest_job_first_pool.sv
